### rtl/core/da96_pkg.sv
// ----------------------------------------------------------------------------
// da96_pkg: shared types and constants for the decimal add/subtract core
// Mantissa width, scale limits and sequencer state encoding.
// ----------------------------------------------------------------------------
package da96_pkg;

  localparam int unsigned MantW          = 96;
  localparam int unsigned ScaleW         = 5;
  localparam int unsigned ScaleLimitDflt = 28;

  // Divide-by-ten works on the mantissa one chunk per cycle, high chunk first.
  localparam int unsigned ChunkW   = 24;
  localparam int unsigned DivSteps = MantW / ChunkW;

  typedef logic [MantW-1:0]  mant_t;
  typedef logic [ScaleW-1:0] scale_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN_UP,
    ST_ALIGN_DN,
    ST_ADD,
    ST_RETRY_A,
    ST_RETRY_B,
    ST_DONE
  } state_e;

  // Shared digit unit operation select.
  typedef enum logic [1:0] {
    OP_MUL10,
    OP_DIVSTEP,
    OP_ROUND
  } dop_e;

endpackage

### rtl/core/da96_digit_unit.sv
// ----------------------------------------------------------------------------
// da96_digit_unit: shared times-ten and round-off-one-digit unit
// Multiplies a 96-bit mantissa by ten with overflow detect, divides one
// chunk by ten (rotating the quotient chunk in at the bottom), or rounds
// the finished quotient half to even on the last kept digit.
// ----------------------------------------------------------------------------
module da96_digit_unit import da96_pkg::*; (
  input  dop_e       op_i,
  input  mant_t      val_i,
  input  logic [3:0] rem_i,
  output mant_t      res_o,
  output logic [3:0] rem_o,
  output logic       ovf_o
);

  localparam int unsigned XW = ChunkW + 4;
  // ceil(2^(XW+3) / 10): exact quotient for any x below 10 * 2^ChunkW
  localparam logic [XW-1:0] Recip = XW'((64'd1 << (XW + 3)) / 64'd10 + 64'd1);

  logic [MantW+3:0] prod;
  logic [XW-1:0]    x;
  logic [2*XW-1:0]  dprod;
  logic [ChunkW-1:0] q;
  logic [XW-1:0]    back;
  logic [3:0]       rem;
  logic             up;

  assign prod  = {1'b0, val_i, 3'b000} + {3'b000, val_i, 1'b0};
  assign x     = {rem_i, val_i[MantW-1 -: ChunkW]};
  assign dprod = {{XW{1'b0}}, x} * {{XW{1'b0}}, Recip};
  assign q     = dprod[XW+3 +: ChunkW];
  assign back  = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
  assign rem   = 4'(x - back);
  assign up    = (rem_i > 4'd5) || ((rem_i == 4'd5) && val_i[0]);

  always_comb begin
    res_o = val_i;
    rem_o = 4'd0;
    ovf_o = 1'b0;
    case (op_i)
      OP_MUL10: begin
        res_o = prod[MantW-1:0];
        ovf_o = |prod[MantW+3:MantW];
      end
      OP_DIVSTEP: begin
        res_o = {val_i[MantW-ChunkW-1:0], q};
        rem_o = rem;
      end
      OP_ROUND: begin
        res_o = val_i + mant_t'(up);
      end
      default: begin
        res_o = val_i;
      end
    endcase
  end

endmodule

### rtl/core/decimal96_add_sub_core.sv
// ----------------------------------------------------------------------------
// decimal96_add_sub_core: 96-bit decimal add/subtract
// Sequenced scale alignment and rounding around one shared digit unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input item on s_axis (command, operands a and b); one result item on
//   m_axis (mantissa, scale, sign, status) per input item.
//   The core handles one item at a time: s_axis_tready is high only
//   while the sequencer is idle.
//   Sequence: the lower-scale operand is multiplied by ten until the scales
//   match, or, when a times-ten would overflow, the other drops digits (4
//   divide steps and a round step each); an overflow retry drops a digit from both.
//   A new item is taken the cycle after a result is registered.
//   Each step uses the single times-ten/divide-by-ten unit.
//   Reset clears the sequencer and output valid; no item is in flight.
//   If the receiver stalls, the result holds on m_axis until taken; the
//   next item is still accepted and processed, then waits for the slot.
// ----------------------------------------------------------------------------
module decimal96_add_sub_core import da96_pkg::*; #(
  parameter int unsigned SCALE_LIMIT = ScaleLimitDflt
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[0], a_mantissa_low[64:1], a_mantissa_high[96:65], a_scale[101:97],
  // a_negative[102], b_mantissa_low[166:103], b_mantissa_high[198:167],
  // b_scale[203:199], b_negative[204], zero pad
  input  logic [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sum_mantissa_low[63:0], sum_mantissa_high[95:64], sum_scale[100:96],
  // sum_negative[101], status[102], zero pad
  output logic [103:0] m_axis_tdata
);

  localparam scale_t MaxS = scale_t'(SCALE_LIMIT);

  state_e state_q, state_d;
  mant_t  a_q, a_d, b_q, b_d;
  scale_t sa_q, sa_d, sb_q, sb_d;
  logic   na_q, na_d, nb_q, nb_d;
  logic   ovld_q, ovld_d;
  logic [103:0] out_q, out_d;
  logic [2:0]   step_q, step_d;
  logic [3:0]   rem_q, rem_d;

  dop_e       dop;
  mant_t      du_in, du_res;
  logic [3:0] du_rem;
  logic       du_ovf;

  da96_digit_unit u_du (
    .op_i (dop),
    .val_i(du_in),
    .rem_i(rem_q),
    .res_o(du_res),
    .rem_o(du_rem),
    .ovf_o(du_ovf)
  );

  logic   a_low;
  logic   rnd_step;
  scale_t sin_a, sin_b;
  logic [MantW:0] sum;
  logic   a_le_b;

  assign a_low    = sa_q < sb_q;
  assign rnd_step = step_q == 3'(DivSteps);
  assign sum      = {1'b0, a_q} + {1'b0, b_q};
  assign a_le_b   = a_q <= b_q;
  assign sin_a    = (s_axis_tdata[101:97] > MaxS) ? MaxS : s_axis_tdata[101:97];
  assign sin_b    = (s_axis_tdata[203:199] > MaxS) ? MaxS : s_axis_tdata[203:199];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  // digit unit input select
  always_comb begin
    dop   = rnd_step ? OP_ROUND : OP_DIVSTEP;
    du_in = b_q;
    case (state_q)
      ST_ALIGN_UP: begin
        dop   = OP_MUL10;
        du_in = a_low ? a_q : b_q;
      end
      ST_ALIGN_DN: du_in = a_low ? b_q : a_q;
      ST_RETRY_A:  du_in = a_q;
      default:     du_in = b_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_axis_tvalid && s_axis_tready) state_d = ST_ALIGN_UP;
      ST_ALIGN_UP: begin
        if (sa_q == sb_q) state_d = ST_ADD;
        else if ((a_low ? sa_q : sb_q) >= MaxS || du_ovf) state_d = ST_ALIGN_DN;
      end
      ST_ALIGN_DN: if (rnd_step &&
                       (a_low ? sb_q : sa_q) == (a_low ? sa_q : sb_q) + 5'd1)
                     state_d = ST_ADD;
      ST_ADD: begin
        if (na_q == nb_q && sum[MantW] && sa_q != '0) state_d = ST_RETRY_A;
        else state_d = ST_DONE;
      end
      ST_RETRY_A:  if (rnd_step) state_d = ST_RETRY_B;
      ST_RETRY_B:  if (rnd_step) state_d = ST_ADD;
      ST_DONE:     if (!ovld_q || m_axis_tready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    a_d = a_q; b_d = b_q; sa_d = sa_q; sb_d = sb_q;
    na_d = na_q; nb_d = nb_q; out_d = out_q;
    step_d = '0;
    rem_d  = '0;
    ovld_d = ovld_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        a_d  = {s_axis_tdata[96:65], s_axis_tdata[64:1]};
        b_d  = {s_axis_tdata[198:167], s_axis_tdata[166:103]};
        sa_d = sin_a;
        sb_d = sin_b;
        na_d = s_axis_tdata[102];
        nb_d = s_axis_tdata[204] ^ s_axis_tdata[0];
      end
      ST_ALIGN_UP: if (sa_q != sb_q && !((a_low ? sa_q : sb_q) >= MaxS || du_ovf)) begin
        if (a_low) begin a_d = du_res; sa_d = sa_q + 5'd1; end
        else begin b_d = du_res; sb_d = sb_q + 5'd1; end
      end
      ST_ALIGN_DN: begin
        step_d = rnd_step ? 3'd0 : step_q + 3'd1;
        rem_d  = du_rem;
        if (a_low) begin
          b_d = du_res;
          if (rnd_step) sb_d = sb_q - 5'd1;
        end else begin
          a_d = du_res;
          if (rnd_step) sa_d = sa_q - 5'd1;
        end
      end
      ST_RETRY_A: begin
        step_d = rnd_step ? 3'd0 : step_q + 3'd1;
        rem_d  = du_rem;
        a_d    = du_res;
      end
      ST_RETRY_B: begin
        step_d = rnd_step ? 3'd0 : step_q + 3'd1;
        rem_d  = du_rem;
        b_d    = du_res;
        if (rnd_step) begin
          sa_d = sa_q - 5'd1;
          sb_d = sb_q - 5'd1;
        end
      end
      ST_DONE: if (!ovld_q || m_axis_tready) begin
        ovld_d = 1'b1;
        out_d = '0;
        out_d[100:96] = sa_q;
        if (na_q == nb_q) begin
          out_d[95:0] = sum[MantW-1:0];
          out_d[101]  = na_q;
          out_d[102]  = sum[MantW];
        end else if (a_le_b) begin
          out_d[95:0] = b_q - a_q;
          out_d[101]  = nb_q;
        end else begin
          out_d[95:0] = a_q - b_q;
          out_d[101]  = na_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
      step_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      step_q  <= step_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; sa_q <= sa_d; sb_q <= sb_d;
    na_q <= na_d; nb_q <= nb_d; out_q <= out_d;
  end

endmodule
